// ===== sv/trb_pkg.sv =====
// Shared types, constants and field layout for the triangle rasterizer.
// Used by trb_ram, trb_div and triangle_raster_zbuffer; depends on nothing.
package trb_pkg;

    // Channel and register field widths
    localparam int CFG_W      = 9;
    localparam int CFG_ADDR_W = 1;
    localparam int OP_W       = 2;
    localparam int COORD_W    = 16;
    localparam int VAL_W      = 32;
    localparam int INDEX_W    = 16;
    localparam int IN_DATA_W  = 240;
    localparam int OUT_DATA_W = 64;

    // Build defaults
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_RAM_WIDTH  = 32;
    localparam int DEF_RAM_DEPTH  = 256;

    // Internal datapath widths
    localparam int CW          = 18;  // screen coordinate, Q.4, signed
    localparam int BW          = 15;  // pixel bounds and counters, signed
    localparam int EW          = 48;  // edge functions and area, Q.8, signed
    localparam int DIV_W       = 64;
    localparam int DIV_CNT_W   = 6;
    localparam int RECIP_W     = 48;  // inverse depth, Q.47
    localparam int WGT_W       = 17;  // barycentric weight, Q.16
    localparam int WGT_SHIFT   = 16;
    localparam int HALF_W      = RECIP_W / 2;
    localparam int PROD_W      = WGT_W + HALF_W;
    localparam int RECIP_SHIFT = 47;
    localparam int DEPTH_SHIFT = 63;
    localparam int SUBPIX      = 4;
    localparam int VERTS       = 3;
    localparam int DOT_STEPS   = 6;

    localparam logic [CFG_W-1:0] RESET_DIM = 9'd256;
    localparam logic [VAL_W-1:0] DEPTH_FAR = 32'hFFFF_FFFF;

    // Edge j runs from vertex EDGE_P[j] to EDGE_Q[j]: BC, CA, AB
    localparam int EDGE_P [VERTS] = '{1, 2, 0};
    localparam int EDGE_Q [VERTS] = '{2, 0, 1};

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CANVAS_WIDTH  = 1'b0,
        REG_CANVAS_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_DRAW  = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLEAR,
        S_RD_ADDR,
        S_RD_DATA,
        S_PROD,
        S_CROSS,
        S_EDGE,
        S_INV_GO,
        S_INV_RUN,
        S_PIX,
        S_WGT_GO,
        S_WGT_RUN,
        S_DOT,
        S_DEP_GO,
        S_DEP_RUN,
        S_CMP
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
    } div_rsp_t;

endpackage

// ===== sv/trb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on trb_pkg for default sizes.
module trb_ram #(
    parameter int WIDTH = trb_pkg::DEF_RAM_WIDTH,
    parameter int DEPTH = trb_pkg::DEF_RAM_DEPTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/trb_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, 64-bit operands.
// Depends on trb_pkg for the request and response structs.
module trb_div (
    input  logic              clk,
    input  logic              rst_n,
    input  trb_pkg::div_req_t req,
    output trb_pkg::div_rsp_t rsp
);

    localparam int DW = trb_pkg::DIV_W;

    logic [DW-1:0]                 num_reg;
    logic [DW-1:0]                 den_reg;
    logic [DW-1:0]                 rem_reg;
    logic [DW-1:0]                 quo_reg;
    logic [trb_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [DW:0]                   shifted;
    logic [DW:0]                   diff;
    logic                          ge;

    // Shift in the next dividend bit and trial-subtract
    assign shifted = {rem_reg, num_reg[DW-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = shifted >= {1'b0, den_reg};

    // Iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DW-2:0], 1'b0};
            rem_reg <= ge ? diff[DW-1:0] : shifted[DW-1:0];
            quo_reg <= {quo_reg[DW-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ===== sv/triangle_raster_zbuffer.sv =====
// Triangle rasterizer with a depth buffer: sequencer, edge walker and pixel stores.
// Depends on trb_pkg, trb_ram (color and depth stores) and trb_div (shared divider).
//
// Usage:
//   s_axis carries commands; tuser selects clear, draw or read, tdata holds the
//   vertices, depths, fill color and read index. m_axis returns one transfer per
//   read (color and depth). Clear and draw return nothing.
//   The block takes one command at a time; s_axis_tready is high when idle.
//   Clear sweeps both stores, one entry per cycle, over all MAX_WIDTH*MAX_HEIGHT entries.
//   Read passes through the address and data states to the output register, then waits for m_axis_tready.
//   Draw first sets up the triangle and computes three depth reciprocals on the
//   shared divider, then visits each pixel of the clamped bounding box; each
//   covered pixel takes three weight divisions,
//   a six-step dot product and one depth division, all on the same divider.
//   The stores power up undefined; issue a clear before the first draw or read.
//   Reset sets both canvas registers to 256 and returns to idle; store contents
//   are not touched. A stalled receiver only holds the output register; a new
//   read waits in the read stage until that register is free.
//   Config writes go through cfg_we/cfg_addr/cfg_wdata; write only while idle.
module triangle_raster_zbuffer #(
    parameter int MAX_WIDTH  = trb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = trb_pkg::DEF_MAX_HEIGHT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [trb_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [trb_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // ax, ay, az, bx, by, bz, cx, cy, cz, fill_color, read_index
    input  logic [trb_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // opcode
    input  logic [trb_pkg::OP_W-1:0]           s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // read_color, read_depth
    output logic [trb_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW         = $clog2(STORE_SIZE);
    localparam int DIMW_X     = $clog2(MAX_WIDTH + 1);
    localparam int DIMW_Y     = $clog2(MAX_HEIGHT + 1);
    localparam int CW         = trb_pkg::CW;
    localparam int BW         = trb_pkg::BW;
    localparam int EW         = trb_pkg::EW;
    localparam int DW         = trb_pkg::DIV_W;
    localparam int VW         = trb_pkg::VAL_W;
    localparam int NV         = trb_pkg::VERTS;
    localparam int PW         = 2 * CW;
    localparam int MW         = CW + 1 + BW;

    trb_pkg::state_t state_reg, state_next;

    // Configuration
    logic [trb_pkg::CFG_W-1:0] cw_reg, ch_reg;
    logic [DIMW_X-1:0]         w_eff;
    logic [DIMW_Y-1:0]         h_eff;
    logic signed [CW-1:0]      ox, oy;
    logic signed [BW-1:0]      w_lim, h_lim;

    // Captured command
    logic signed [CW-1:0] vx_reg [NV];
    logic signed [CW-1:0] vy_reg [NV];
    logic [VW-1:0]        vz_reg [NV];
    logic [VW-1:0]        color_reg;
    logic [AW-1:0]        rd_addr_reg;
    logic                 rd_oob_reg;
    logic [AW-1:0]        clr_addr_reg;

    // Triangle setup
    logic signed [PW-1:0] pa_reg [NV];
    logic signed [PW-1:0] pb_reg [NV];
    logic signed [CW:0]   dy_reg [NV];
    logic signed [CW:0]   dx_reg [NV];
    logic signed [PW:0]   cross_reg [NV];
    logic signed [MW-1:0] dyx_reg [NV];
    logic signed [MW-1:0] dxy_reg [NV];
    logic signed [BW-1:0] x0_reg, x1_reg, y0_reg, y1_reg;
    logic [AW-1:0]        base_reg;
    logic signed [EW-1:0] area_reg;

    // Pixel walk
    logic signed [BW-1:0] col_reg, row_reg;
    logic [AW-1:0]        addr_reg, rowbase_reg;
    logic signed [EW-1:0] e_reg [NV];
    logic signed [EW-1:0] er_reg [NV];

    // Shading
    logic [1:0]                     k_reg;
    logic [2:0]                     m_reg;
    logic [trb_pkg::RECIP_W-1:0]    r_reg [NV];
    logic [trb_pkg::WGT_W-1:0]      wt_reg [NV];
    logic [trb_pkg::PROD_W-1:0]     prod_reg;
    logic                           hi_reg;
    logic [DW-1:0]                  acc_reg;
    logic [VW-1:0]                  z_reg;

    // Output register
    logic          out_valid_reg;
    logic [VW-1:0] out_color_reg, out_depth_reg;
    logic          out_free;

    // Combinational setup values
    logic signed [CW-1:0]   xmin, xmax, ymin, ymax;
    logic signed [CW:0]     xceil, yceil;
    logic signed [BW-1:0]   fx, fy, cx_b, cy_b;
    logic signed [BW-1:0]   x0_next, x1_next, y0_next, y1_next;
    logic [BW+DIMW_X-1:0]   yw;
    logic signed [EW-1:0]   er_next [NV];
    logic signed [EW-1:0]   area_next;
    logic signed [EW-1:0]   sx [NV];
    logic signed [EW-1:0]   sy [NV];

    // Walk advance
    logic                 covered;
    logic signed [BW-1:0] col_plus, row_plus;
    logic                 col_end, last_pix;
    logic signed [BW-1:0] col_adv, row_adv;
    logic [AW-1:0]        addr_adv, rowbase_adv;
    logic signed [EW-1:0] e_adv [NV];
    logic signed [EW-1:0] er_adv [NV];

    // Memory and divider hookup
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [VW-1:0] col_wdata, dep_wdata, col_rdata, dep_rdata;
    trb_pkg::div_req_t div_req;
    trb_pkg::div_rsp_t div_rsp;
    logic [trb_pkg::HALF_W-1:0] r_half;
    logic [1:0]                 dot_i;

    trb_ram #(
        .WIDTH (VW),
        .DEPTH (STORE_SIZE)
    ) u_color_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (col_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (col_rdata)
    );

    trb_ram #(
        .WIDTH (VW),
        .DEPTH (STORE_SIZE)
    ) u_depth_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (dep_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (dep_rdata)
    );

    trb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Clamp the canvas registers to the built size; a zero value counts as one
    always_comb
    begin
        if (cw_reg == '0)
        begin
            w_eff = DIMW_X'(1);
        end
        else if (32'(cw_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = DIMW_X'(MAX_WIDTH);
        end
        else
        begin
            w_eff = DIMW_X'(cw_reg);
        end
        if (ch_reg == '0)
        begin
            h_eff = DIMW_Y'(1);
        end
        else if (32'(ch_reg) > 32'(MAX_HEIGHT))
        begin
            h_eff = DIMW_Y'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = DIMW_Y'(ch_reg);
        end
    end

    assign ox    = $signed(CW'(w_eff >> 1) << trb_pkg::SUBPIX);
    assign oy    = $signed(CW'(h_eff >> 1) << trb_pkg::SUBPIX);
    assign w_lim = $signed(BW'(w_eff) - BW'(1));
    assign h_lim = $signed(BW'(h_eff) - BW'(1));

    // Bounding box: floor of the minimum, ceiling of the maximum, then clamp
    always_comb
    begin
        xmin = vx_reg[0];
        xmax = vx_reg[0];
        ymin = vy_reg[0];
        ymax = vy_reg[0];
        for (int j = 1; j < NV; j++)
        begin
            if (vx_reg[j] < xmin) xmin = vx_reg[j];
            if (vx_reg[j] > xmax) xmax = vx_reg[j];
            if (vy_reg[j] < ymin) ymin = vy_reg[j];
            if (vy_reg[j] > ymax) ymax = vy_reg[j];
        end
        xceil = (CW+1)'(xmax) + (CW+1)'(15);
        yceil = (CW+1)'(ymax) + (CW+1)'(15);
        fx    = BW'(xmin >>> trb_pkg::SUBPIX);
        fy    = BW'(ymin >>> trb_pkg::SUBPIX);
        cx_b  = BW'(xceil >>> trb_pkg::SUBPIX);
        cy_b  = BW'(yceil >>> trb_pkg::SUBPIX);
        x0_next = fx[BW-1] ? '0 : fx;
        y0_next = fy[BW-1] ? '0 : fy;
        x1_next = (cx_b > w_lim) ? w_lim : cx_b;
        y1_next = (cy_b > h_lim) ? h_lim : cy_b;
    end

    // Edge values at the box corner, area and per-pixel steps
    always_comb
    begin
        area_next = '0;
        for (int j = 0; j < NV; j++)
        begin
            er_next[j] = ((EW'(dyx_reg[j]) - EW'(dxy_reg[j])) <<< trb_pkg::SUBPIX)
                         + EW'(cross_reg[j]);
            area_next  = area_next + EW'(cross_reg[j]);
            sx[j]      = EW'(dy_reg[j]) <<< trb_pkg::SUBPIX;
            sy[j]      = -(EW'(dx_reg[j]) <<< trb_pkg::SUBPIX);
        end
    end

    assign yw = $unsigned(y0_reg) * w_eff;

    // Coverage and next pixel in the walk
    assign covered  = !e_reg[0][EW-1] && !e_reg[1][EW-1] && !e_reg[2][EW-1];
    assign col_plus = col_reg + BW'(1);
    assign row_plus = row_reg + BW'(1);
    assign col_end  = col_plus >= x1_reg;
    assign last_pix = col_end && (row_plus >= y1_reg);

    always_comb
    begin
        if (!col_end)
        begin
            col_adv     = col_plus;
            row_adv     = row_reg;
            addr_adv    = addr_reg + AW'(1);
            rowbase_adv = rowbase_reg;
            for (int j = 0; j < NV; j++)
            begin
                e_adv[j]  = e_reg[j] + sx[j];
                er_adv[j] = er_reg[j];
            end
        end
        else
        begin
            col_adv     = x0_reg;
            row_adv     = row_plus;
            addr_adv    = rowbase_reg + AW'(w_eff);
            rowbase_adv = rowbase_reg + AW'(w_eff);
            for (int j = 0; j < NV; j++)
            begin
                e_adv[j]  = er_reg[j] + sy[j];
                er_adv[j] = er_reg[j] + sy[j];
            end
        end
    end

    assign out_free = !out_valid_reg || m_axis_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            trb_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    case (trb_pkg::opcode_t'(s_axis_tuser))
                        trb_pkg::OP_CLEAR: state_next = trb_pkg::S_CLEAR;
                        trb_pkg::OP_DRAW:  state_next = trb_pkg::S_PROD;
                        trb_pkg::OP_READ:  state_next = trb_pkg::S_RD_ADDR;
                        default:           state_next = trb_pkg::S_IDLE;
                    endcase
                end
            end
            trb_pkg::S_CLEAR:
            begin
                if (clr_addr_reg == AW'(STORE_SIZE - 1))
                begin
                    state_next = trb_pkg::S_IDLE;
                end
            end
            trb_pkg::S_RD_ADDR: state_next = trb_pkg::S_RD_DATA;
            trb_pkg::S_RD_DATA:
            begin
                if (out_free)
                begin
                    state_next = trb_pkg::S_IDLE;
                end
            end
            trb_pkg::S_PROD:  state_next = trb_pkg::S_CROSS;
            trb_pkg::S_CROSS: state_next = trb_pkg::S_EDGE;
            trb_pkg::S_EDGE:
            begin
                if (area_next[EW-1] || area_next == '0 || x0_reg >= x1_reg
                    || y0_reg >= y1_reg)
                begin
                    state_next = trb_pkg::S_IDLE;
                end
                else
                begin
                    state_next = trb_pkg::S_INV_GO;
                end
            end
            trb_pkg::S_INV_GO: state_next = trb_pkg::S_INV_RUN;
            trb_pkg::S_INV_RUN:
            begin
                if (div_rsp.done)
                begin
                    state_next = (k_reg == 2'(NV - 1)) ? trb_pkg::S_PIX : trb_pkg::S_INV_GO;
                end
            end
            trb_pkg::S_PIX:
            begin
                if (covered)
                begin
                    state_next = trb_pkg::S_WGT_GO;
                end
                else if (last_pix)
                begin
                    state_next = trb_pkg::S_IDLE;
                end
            end
            trb_pkg::S_WGT_GO: state_next = trb_pkg::S_WGT_RUN;
            trb_pkg::S_WGT_RUN:
            begin
                if (div_rsp.done)
                begin
                    state_next = (k_reg == 2'(NV - 1)) ? trb_pkg::S_DOT : trb_pkg::S_WGT_GO;
                end
            end
            trb_pkg::S_DOT:
            begin
                if (m_reg == 3'(trb_pkg::DOT_STEPS))
                begin
                    state_next = trb_pkg::S_DEP_GO;
                end
            end
            trb_pkg::S_DEP_GO: state_next = trb_pkg::S_DEP_RUN;
            trb_pkg::S_DEP_RUN:
            begin
                if (div_rsp.done)
                begin
                    state_next = trb_pkg::S_CMP;
                end
            end
            trb_pkg::S_CMP:
            begin
                state_next = last_pix ? trb_pkg::S_IDLE : trb_pkg::S_PIX;
            end
            default: state_next = trb_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake, store ports, divider request
    always_comb
    begin
        s_axis_tready = (state_reg == trb_pkg::S_IDLE);
        ram_we        = 1'b0;
        ram_waddr     = addr_reg;
        col_wdata     = color_reg;
        dep_wdata     = z_reg;
        ram_re        = 1'b0;
        ram_raddr     = addr_reg;
        div_req       = '0;
        case (state_reg)
            trb_pkg::S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                col_wdata = '0;
                dep_wdata = trb_pkg::DEPTH_FAR;
            end
            trb_pkg::S_RD_ADDR:
            begin
                ram_re    = 1'b1;
                ram_raddr = rd_addr_reg;
            end
            trb_pkg::S_PIX:
            begin
                ram_re = covered;
            end
            trb_pkg::S_CMP:
            begin
                ram_we = z_reg < dep_rdata;
            end
            trb_pkg::S_INV_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = DW'(1) << trb_pkg::RECIP_SHIFT;
                div_req.den   = (vz_reg[k_reg] == '0) ? DW'(1) : DW'(vz_reg[k_reg]);
            end
            trb_pkg::S_WGT_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = DW'({e_reg[k_reg][EW-trb_pkg::WGT_SHIFT-1:0],
                                     {trb_pkg::WGT_SHIFT{1'b0}}});
                div_req.den   = DW'($unsigned(area_reg));
            end
            trb_pkg::S_DEP_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = DW'(1) << trb_pkg::DEPTH_SHIFT;
                div_req.den   = acc_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= trb_pkg::S_IDLE;
            cw_reg        <= trb_pkg::RESET_DIM;
            ch_reg        <= trb_pkg::RESET_DIM;
            k_reg         <= '0;
            m_reg         <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (trb_pkg::cfg_reg_t'(cfg_addr))
                    trb_pkg::REG_CANVAS_WIDTH:  cw_reg <= cfg_wdata;
                    trb_pkg::REG_CANVAS_HEIGHT: ch_reg <= cfg_wdata;
                    default:                    cw_reg <= cw_reg;
                endcase
            end

            // Clear sweep address
            if (state_reg == trb_pkg::S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            else
            begin
                clr_addr_reg <= '0;
            end

            // Vertex index for the reciprocal and weight passes
            if (state_reg == trb_pkg::S_EDGE)
            begin
                k_reg <= '0;
            end
            else if ((state_reg == trb_pkg::S_INV_RUN || state_reg == trb_pkg::S_WGT_RUN)
                     && div_rsp.done)
            begin
                k_reg <= (k_reg == 2'(NV - 1)) ? 2'd0 : k_reg + 2'd1;
            end

            // Dot product step
            if (state_reg == trb_pkg::S_DOT)
            begin
                m_reg <= m_reg + 3'd1;
            end
            else
            begin
                m_reg <= '0;
            end

            // Output register: load on a read, drop on transfer
            if (state_reg == trb_pkg::S_RD_DATA && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign dot_i  = m_reg[2:1];
    assign r_half = m_reg[0] ? r_reg[dot_i][trb_pkg::RECIP_W-1:trb_pkg::HALF_W]
                             : r_reg[dot_i][trb_pkg::HALF_W-1:0];

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            trb_pkg::S_IDLE:
            begin
                // Capture the command, shifting vertices to the canvas corner
                vx_reg[0] <= CW'($signed(s_axis_tdata[15:0]))    + ox;
                vy_reg[0] <= CW'($signed(s_axis_tdata[31:16]))   + oy;
                vz_reg[0] <= s_axis_tdata[63:32];
                vx_reg[1] <= CW'($signed(s_axis_tdata[79:64]))   + ox;
                vy_reg[1] <= CW'($signed(s_axis_tdata[95:80]))   + oy;
                vz_reg[1] <= s_axis_tdata[127:96];
                vx_reg[2] <= CW'($signed(s_axis_tdata[143:128])) + ox;
                vy_reg[2] <= CW'($signed(s_axis_tdata[159:144])) + oy;
                vz_reg[2] <= s_axis_tdata[191:160];
                color_reg <= s_axis_tdata[223:192];
                rd_oob_reg  <= !(32'(s_axis_tdata[239:224]) < 32'(STORE_SIZE));
                rd_addr_reg <= AW'(32'(s_axis_tdata[239:224]));
            end
            trb_pkg::S_RD_DATA:
            begin
                if (out_free)
                begin
                    out_color_reg <= rd_oob_reg ? '0 : col_rdata;
                    out_depth_reg <= rd_oob_reg ? '0 : dep_rdata;
                end
            end
            trb_pkg::S_PROD:
            begin
                for (int j = 0; j < NV; j++)
                begin
                    pa_reg[j] <= vx_reg[trb_pkg::EDGE_Q[j]] * vy_reg[trb_pkg::EDGE_P[j]];
                    pb_reg[j] <= vx_reg[trb_pkg::EDGE_P[j]] * vy_reg[trb_pkg::EDGE_Q[j]];
                    dy_reg[j] <= (CW+1)'(vy_reg[trb_pkg::EDGE_Q[j]])
                                 - (CW+1)'(vy_reg[trb_pkg::EDGE_P[j]]);
                    dx_reg[j] <= (CW+1)'(vx_reg[trb_pkg::EDGE_Q[j]])
                                 - (CW+1)'(vx_reg[trb_pkg::EDGE_P[j]]);
                end
                x0_reg <= x0_next;
                x1_reg <= x1_next;
                y0_reg <= y0_next;
                y1_reg <= y1_next;
            end
            trb_pkg::S_CROSS:
            begin
                for (int j = 0; j < NV; j++)
                begin
                    cross_reg[j] <= (PW+1)'(pa_reg[j]) - (PW+1)'(pb_reg[j]);
                    dyx_reg[j]   <= dy_reg[j] * x0_reg;
                    dxy_reg[j]   <= dx_reg[j] * y0_reg;
                end
                base_reg <= AW'(yw) + AW'($unsigned(x0_reg));
            end
            trb_pkg::S_EDGE:
            begin
                for (int j = 0; j < NV; j++)
                begin
                    e_reg[j]  <= er_next[j];
                    er_reg[j] <= er_next[j];
                end
                area_reg    <= area_next;
                col_reg     <= x0_reg;
                row_reg     <= y0_reg;
                addr_reg    <= base_reg;
                rowbase_reg <= base_reg;
            end
            trb_pkg::S_INV_RUN:
            begin
                if (div_rsp.done)
                begin
                    r_reg[k_reg] <= div_rsp.quo[trb_pkg::RECIP_W-1:0];
                end
            end
            trb_pkg::S_WGT_RUN:
            begin
                if (div_rsp.done)
                begin
                    wt_reg[k_reg] <= div_rsp.quo[trb_pkg::WGT_W-1:0];
                    acc_reg       <= '0;
                end
            end
            trb_pkg::S_DOT:
            begin
                // One weight-by-half-reciprocal product per cycle, accumulated in the next cycle
                if (m_reg < 3'(trb_pkg::DOT_STEPS))
                begin
                    prod_reg <= wt_reg[dot_i] * r_half;
                    hi_reg   <= m_reg[0];
                end
                if (m_reg != '0)
                begin
                    acc_reg <= acc_reg + (hi_reg ? (DW'(prod_reg) << trb_pkg::HALF_W)
                                                 : DW'(prod_reg));
                end
            end
            trb_pkg::S_DEP_RUN:
            begin
                if (div_rsp.done)
                begin
                    z_reg <= (acc_reg == '0 || div_rsp.quo[DW-1:VW] != '0)
                             ? trb_pkg::DEPTH_FAR : div_rsp.quo[VW-1:0];
                end
            end
            trb_pkg::S_PIX,
            trb_pkg::S_CMP:
            begin
                // Advance the walk unless a covered pixel still needs shading
                if (state_reg == trb_pkg::S_CMP || !covered)
                begin
                    col_reg     <= col_adv;
                    row_reg     <= row_adv;
                    addr_reg    <= addr_adv;
                    rowbase_reg <= rowbase_adv;
                    for (int j = 0; j < NV; j++)
                    begin
                        e_reg[j]  <= e_adv[j];
                        er_reg[j] <= er_adv[j];
                    end
                end
            end
            default:
            begin
                hi_reg <= hi_reg;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_depth_reg, out_color_reg};

endmodule
